FILE: design/apcs_pkg.sv
`default_nettype none
package apcs_pkg;

   localparam logic [2:0] ACT_ENQUEUE  = 3'd0;
   localparam logic [2:0] ACT_RESPONSE = 3'd1;
   localparam logic [2:0] ACT_ERROR    = 3'd2;
   localparam logic [2:0] ACT_TICK     = 3'd3;
   localparam logic [2:0] ACT_CLEAR    = 3'd4;

   localparam logic [1:0] KIND_ISSUE  = 2'd0;
   localparam logic [1:0] KIND_OK     = 2'd1;
   localparam logic [1:0] KIND_FAIL   = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   localparam logic [1:0] MERGE_LOW_PRI = 2'd0;
   localparam logic [1:0] MERGE_ALWAYS  = 2'd1;

   localparam logic [2:0] PRI_NORMAL     = 3'd2;
   localparam logic [2:0] PRI_BACKGROUND = 3'd3;
   localparam logic [2:0] PRI_IDLE       = 3'd4;

   localparam logic [1:0] REG_TIMEOUT    = 2'd0;
   localparam logic [1:0] REG_BG_PENALTY = 2'd1;
   localparam logic [1:0] REG_IDLE_PEN   = 2'd2;

   localparam logic [31:0] TIMEOUT_RESET    = 32'd1000;
   localparam logic [30:0] BG_PENALTY_RESET = 31'd1000;
   localparam logic [30:0] IDLE_PEN_RESET   = 31'd5000;

   typedef struct packed {
      logic [31:0] timeout_limit;
      logic [30:0] background_penalty;
      logic [30:0] idle_penalty;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_DISPATCH,
      OP_MSCAN,
      OP_APPEND,
      OP_RESP,
      OP_ERR,
      OP_TICK,
      OP_TMO,
      OP_CLR,
      OP_ICHK,
      OP_PICK,
      OP_ISSUE,
      OP_FLUSH
   } dp_op_type;

   typedef struct packed {
      logic [2:0] action;
      logic       want_merge;
      logic       head_match;
      logic       fill_zero;
      logic       scan_end;
      logic       hit;
      logic       go_pick;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MSCAN,
      ST_APPEND,
      ST_RESP,
      ST_ERR,
      ST_TICK,
      ST_TMO,
      ST_CLR,
      ST_ICHK,
      ST_PICK,
      ST_ISSUE,
      ST_FLUSH
   } state_type;

endpackage
`default_nettype wire

FILE: design/apcs_ctrl.sv
`default_nettype none
module apcs_ctrl
   import apcs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type status,
   output dp_op_type          op,
   output logic               busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               op       = OP_LATCH;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            op = OP_DISPATCH;
            case (status.action)
               ACT_ENQUEUE:  state_in = status.want_merge ? ST_MSCAN : ST_APPEND;
               ACT_RESPONSE: state_in = status.head_match ? ST_RESP : ST_FLUSH;
               ACT_ERROR:    state_in = status.head_match ? ST_ERR : ST_FLUSH;
               ACT_TICK:     state_in = ST_TICK;
               ACT_CLEAR:    state_in = status.fill_zero ? ST_FLUSH : ST_CLR;
               default:      state_in = ST_FLUSH;
            endcase
         end
         ST_MSCAN: begin
            op = OP_MSCAN;
            if (status.scan_end) begin
               state_in = ST_APPEND;
            end else if (status.hit) begin
               state_in = ST_FLUSH;
            end
         end
         ST_APPEND: begin
            op       = OP_APPEND;
            state_in = status.fill_zero ? ST_ICHK : ST_ICHK;
         end
         ST_RESP: begin
            op       = OP_RESP;
            state_in = ST_ICHK;
         end
         ST_ERR: begin
            op       = OP_ERR;
            state_in = ST_ICHK;
         end
         ST_TICK: begin
            op       = OP_TICK;
            state_in = ST_TMO;
         end
         ST_TMO: begin
            op       = OP_TMO;
            state_in = ST_ICHK;
         end
         ST_CLR: begin
            op = OP_CLR;
            if (status.scan_end) begin
               state_in = ST_ICHK;
            end
         end
         ST_ICHK: begin
            op       = OP_ICHK;
            state_in = status.go_pick ? ST_PICK : ST_FLUSH;
         end
         ST_PICK: begin
            op = OP_PICK;
            if (status.scan_end) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            op       = OP_ISSUE;
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            op       = OP_FLUSH;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: design/apcs_dp.sv
`default_nettype none
module apcs_dp
   import apcs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 32,
   parameter int WAITER_BITS  = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dp_op_type               op,
   input  wire cfg_type                 cfg,
   input  wire logic [2:0]              req_action,
   input  wire logic [15:0]             req_command_type,
   input  wire logic [PAYLOAD_BITS-1:0] req_payload,
   input  wire logic [2:0]              req_priority_req,
   input  wire logic [15:0]             req_delay_after,
   input  wire logic [1:0]              req_merge_mode,
   input  wire logic                    req_has_waiter,
   output dp_status_type                status,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_kind,
   output logic [15:0]                  rsp_out_type,
   output logic [PAYLOAD_BITS-1:0]      rsp_out_payload,
   output logic [WAITER_BITS-1:0]       rsp_waiters,
   output logic                         rsp_last
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PB = PAYLOAD_BITS;
   localparam int WB = WAITER_BITS;

   logic [15:0]    type_ff [QUEUE_DEPTH];
   logic [PB-1:0]  pay_ff  [QUEUE_DEPTH];
   logic [2:0]     pri_ff  [QUEUE_DEPTH];
   logic [15:0]    dly_ff  [QUEUE_DEPTH];
   logic [31:0]    enq_ff  [QUEUE_DEPTH];
   logic [WB-1:0]  wt_ff   [QUEUE_DEPTH];

   logic [CW-1:0]  fill_ff, ptr_ff;
   logic [IW-1:0]  best_ff;
   logic signed [33:0] beff_ff;
   logic           infl_ff, dv_ff;
   logic [31:0]    iss_ff, now_ff, hst_ff;
   logic [15:0]    hlen_ff;
   logic [15:0]    dtype_ff;
   logic [PB-1:0]  dpay_ff;
   logic [WB-1:0]  dwt_ff;

   logic [2:0]     act_ff, pri_in_ff;
   logic [15:0]    ityp_ff, idly_ff;
   logic [PB-1:0]  ipay_ff;
   logic [1:0]     mode_ff;
   logic           iwt_ff;

   logic           pv_ff;
   logic [1:0]     pk_ff;
   logic [15:0]    ptype_ff;
   logic [PB-1:0]  ppay_ff;
   logic [WB-1:0]  pwt_ff;

   logic [IW-1:0]  pidx;
   logic           scan_end, hit, full, can_issue, tmo_hit, better;
   logic [WB:0]    wsum;
   logic signed [33:0] eff_p;
   logic           emit_v;
   logic [1:0]     e_kind;
   logic [15:0]    e_type;
   logic [PB-1:0]  e_pay;
   logic [WB-1:0]  e_wt;

   function automatic logic signed [33:0] eff_of(input logic [2:0] pri,
                                                input logic [31:0] enq,
                                                input logic [31:0] now,
                                                input cfg_type c);
      logic [31:0] age;
      logic [30:0] pen;
      begin
         age = now - enq;
         if (pri <= PRI_NORMAL) pen = '0;
         else if (pri == PRI_BACKGROUND) pen = c.background_penalty;
         else pen = c.idle_penalty;
         eff_of = $signed({3'b000, pen}) - $signed({2'b00, age});
      end
   endfunction

   assign pidx      = ptr_ff[IW-1:0];
   assign scan_end  = ptr_ff >= fill_ff;
   assign hit       = (type_ff[pidx] == ityp_ff) && (pay_ff[pidx] == ipay_ff);
   assign full      = fill_ff >= CW'(QUEUE_DEPTH);
   assign can_issue = !infl_ff && ((now_ff - hst_ff) >= {16'd0, hlen_ff});
   assign tmo_hit   = infl_ff && (fill_ff != '0) && ((now_ff - iss_ff) > cfg.timeout_limit);
   assign wsum      = {1'b0, wt_ff[pidx]} + {{WB{1'b0}}, iwt_ff};
   assign eff_p     = eff_of(pri_ff[pidx], enq_ff[pidx], now_ff, cfg);
   assign better    = ((pri_ff[pidx] < PRI_NORMAL) || (pri_ff[best_ff] < PRI_NORMAL)) ?
                      (pri_ff[pidx] < pri_ff[best_ff]) : (eff_p < beff_ff);

   always_comb begin
      status.action     = act_ff;
      status.want_merge = (mode_ff == MERGE_LOW_PRI) ?
                          ((pri_in_ff == PRI_BACKGROUND) || (pri_in_ff == PRI_IDLE)) :
                          (mode_ff == MERGE_ALWAYS);
      status.head_match = infl_ff && (fill_ff != '0) && (type_ff[0] == ityp_ff);
      status.fill_zero  = fill_ff == '0;
      status.scan_end   = scan_end;
      status.hit        = hit;
      status.go_pick    = can_issue && (fill_ff != '0);
   end

   always_comb begin
      emit_v = 1'b0;
      e_kind = KIND_FAIL;
      e_type = type_ff[0];
      e_pay  = '0;
      e_wt   = wt_ff[0];
      case (op)
         OP_APPEND: begin
            if (full) begin
               emit_v = 1'b1;
               e_kind = KIND_REJECT;
               e_type = ityp_ff;
               e_pay  = ipay_ff;
               e_wt   = WB'(iwt_ff);
            end
         end
         OP_RESP: begin
            if (dly_ff[0] != '0) begin
               emit_v = dv_ff;
               e_kind = KIND_OK;
               e_type = dtype_ff;
               e_pay  = dpay_ff;
               e_wt   = dwt_ff;
            end else begin
               emit_v = 1'b1;
               e_kind = KIND_OK;
               e_type = ityp_ff;
               e_pay  = ipay_ff;
            end
         end
         OP_ERR:  emit_v = 1'b1;
         OP_TMO:  emit_v = tmo_hit;
         OP_CLR: begin
            emit_v = !scan_end;
            e_type = type_ff[pidx];
            e_wt   = wt_ff[pidx];
         end
         OP_ICHK: begin
            emit_v = can_issue && dv_ff;
            e_kind = KIND_OK;
            e_type = dtype_ff;
            e_pay  = dpay_ff;
            e_wt   = dwt_ff;
         end
         OP_ISSUE: begin
            emit_v = 1'b1;
            e_kind = KIND_ISSUE;
            e_type = type_ff[best_ff];
            e_pay  = pay_ff[best_ff];
            e_wt   = wt_ff[best_ff];
         end
         default: emit_v = 1'b0;
      endcase
   end

   // slot storage, no reset
   always_ff @(posedge clock) begin
      case (op)
         OP_MSCAN: begin
            if (!scan_end && hit) begin
               if (pri_in_ff < pri_ff[pidx]) pri_ff[pidx] <= pri_in_ff;
               dly_ff[pidx] <= idly_ff;
               wt_ff[pidx]  <= wsum[WB] ? {WB{1'b1}} : wsum[WB-1:0];
            end
         end
         OP_APPEND: begin
            if (!full) begin
               type_ff[fill_ff[IW-1:0]] <= ityp_ff;
               pay_ff[fill_ff[IW-1:0]]  <= ipay_ff;
               pri_ff[fill_ff[IW-1:0]]  <= pri_in_ff;
               dly_ff[fill_ff[IW-1:0]]  <= idly_ff;
               enq_ff[fill_ff[IW-1:0]]  <= now_ff;
               wt_ff[fill_ff[IW-1:0]]   <= WB'(iwt_ff);
            end
         end
         OP_RESP, OP_ERR, OP_TMO: begin
            if (op != OP_TMO || tmo_hit) begin
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  type_ff[i] <= type_ff[i+1];
                  pay_ff[i]  <= pay_ff[i+1];
                  pri_ff[i]  <= pri_ff[i+1];
                  dly_ff[i]  <= dly_ff[i+1];
                  enq_ff[i]  <= enq_ff[i+1];
                  wt_ff[i]   <= wt_ff[i+1];
               end
            end
         end
         OP_ISSUE: begin
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
               if (IW'(i) <= best_ff) begin
                  type_ff[i] <= type_ff[i-1];
                  pay_ff[i]  <= pay_ff[i-1];
                  pri_ff[i]  <= pri_ff[i-1];
                  dly_ff[i]  <= dly_ff[i-1];
                  enq_ff[i]  <= enq_ff[i-1];
                  wt_ff[i]   <= wt_ff[i-1];
               end
            end
            type_ff[0] <= type_ff[best_ff];
            pay_ff[0]  <= pay_ff[best_ff];
            pri_ff[0]  <= pri_ff[best_ff];
            dly_ff[0]  <= dly_ff[best_ff];
            enq_ff[0]  <= enq_ff[best_ff];
            wt_ff[0]   <= wt_ff[best_ff];
         end
         default: begin
         end
      endcase
   end

   // input word latch and scan registers
   always_ff @(posedge clock) begin
      if (op == OP_LATCH) begin
         act_ff    <= req_action;
         ityp_ff   <= req_command_type;
         ipay_ff   <= req_payload;
         pri_in_ff <= req_priority_req;
         idly_ff   <= req_delay_after;
         mode_ff   <= req_merge_mode;
         iwt_ff    <= req_has_waiter;
      end
      case (op)
         OP_DISPATCH: ptr_ff <= CW'(infl_ff);
         OP_MSCAN: if (!scan_end && !hit) ptr_ff <= ptr_ff + CW'(1);
         OP_CLR:   if (!scan_end) ptr_ff <= ptr_ff + CW'(1);
         OP_ICHK: begin
            ptr_ff  <= CW'(1);
            best_ff <= '0;
            beff_ff <= eff_of(pri_ff[0], enq_ff[0], now_ff, cfg);
         end
         OP_PICK: begin
            if (!scan_end) begin
               ptr_ff <= ptr_ff + CW'(1);
               if (better) begin
                  best_ff <= pidx;
                  beff_ff <= eff_p;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         infl_ff  <= 1'b0;
         iss_ff   <= '0;
         now_ff   <= '0;
         hst_ff   <= '0;
         hlen_ff  <= '0;
         dv_ff    <= 1'b0;
         dtype_ff <= '0;
         dpay_ff  <= '0;
         dwt_ff   <= '0;
      end else begin
         case (op)
            OP_APPEND: if (!full) fill_ff <= fill_ff + CW'(1);
            OP_RESP: begin
               hst_ff  <= now_ff;
               hlen_ff <= dly_ff[0];
               infl_ff <= 1'b0;
               fill_ff <= fill_ff - CW'(1);
               if (dly_ff[0] != '0) begin
                  dv_ff    <= 1'b1;
                  dtype_ff <= ityp_ff;
                  dpay_ff  <= ipay_ff;
                  dwt_ff   <= wt_ff[0];
               end
            end
            OP_ERR: begin
               hst_ff  <= now_ff;
               hlen_ff <= dly_ff[0];
               infl_ff <= 1'b0;
               fill_ff <= fill_ff - CW'(1);
            end
            OP_TICK: now_ff <= now_ff + 32'd1;
            OP_TMO: begin
               if (tmo_hit) begin
                  infl_ff <= 1'b0;
                  fill_ff <= fill_ff - CW'(1);
               end
            end
            OP_CLR: if (scan_end) fill_ff <= CW'(infl_ff);
            OP_ICHK: begin
               if (can_issue) begin
                  hlen_ff <= '0;
                  dv_ff   <= 1'b0;
               end
            end
            OP_ISSUE: begin
               infl_ff <= 1'b1;
               iss_ff  <= now_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // one word held back so the final one can carry last
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff      <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= pv_ff && (emit_v || op == OP_FLUSH);
         if (emit_v) begin
            pv_ff <= 1'b1;
         end else if (op == OP_FLUSH) begin
            pv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_v || op == OP_FLUSH) begin
         rsp_kind        <= pk_ff;
         rsp_out_type    <= ptype_ff;
         rsp_out_payload <= ppay_ff;
         rsp_waiters     <= pwt_ff;
         rsp_last        <= !emit_v;
      end
      if (emit_v) begin
         pk_ff    <= e_kind;
         ptype_ff <= e_type;
         ppay_ff  <= e_pay;
         pwt_ff   <= e_wt;
      end
   end

endmodule
`default_nettype wire

FILE: design/aged_priority_command_scheduler_core.sv
// Busy after a word is taken, through one-entry-per-cycle scans of the queue
//   for merge, clear and pick.
// One word at a time: start is taken
//   only while busy is low. The last result strobes in the first cycle busy is low.
// Results leave on rsp_strobe, the last one flagged by rsp_last; the receiver cannot stall.
// Reset (synchronous): queue empty, time zero, registers at their defaults.
`default_nettype none
module aged_priority_command_scheduler_core
   import apcs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 32,
   parameter int WAITER_BITS  = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [2:0]              req_action,
   input  wire logic [15:0]             req_command_type,
   input  wire logic [PAYLOAD_BITS-1:0] req_payload,
   input  wire logic [2:0]              req_priority_req,
   input  wire logic [15:0]             req_delay_after,
   input  wire logic [1:0]              req_merge_mode,
   input  wire logic                    req_has_waiter,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_kind,
   output logic [15:0]                  rsp_out_type,
   output logic [PAYLOAD_BITS-1:0]      rsp_out_payload,
   output logic [WAITER_BITS-1:0]       rsp_waiters,
   output logic                         rsp_last,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [3:0]              paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   cfg_type       cfg_ff;
   dp_op_type     op;
   dp_status_type status;
   logic          wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_limit      <= TIMEOUT_RESET;
         cfg_ff.background_penalty <= BG_PENALTY_RESET;
         cfg_ff.idle_penalty       <= IDLE_PEN_RESET;
      end else if (wr_en) begin
         case (paddr[3:2])
            REG_TIMEOUT:    cfg_ff.timeout_limit      <= pwdata;
            REG_BG_PENALTY: cfg_ff.background_penalty <= pwdata[30:0];
            REG_IDLE_PEN:   cfg_ff.idle_penalty       <= pwdata[30:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_TIMEOUT:    prdata = cfg_ff.timeout_limit;
         REG_BG_PENALTY: prdata = {1'b0, cfg_ff.background_penalty};
         REG_IDLE_PEN:   prdata = {1'b0, cfg_ff.idle_penalty};
         default:        prdata = '0;
      endcase
   end

   apcs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   apcs_dp #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .WAITER_BITS  (WAITER_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .cfg              (cfg_ff),
      .req_action       (req_action),
      .req_command_type (req_command_type),
      .req_payload      (req_payload),
      .req_priority_req (req_priority_req),
      .req_delay_after  (req_delay_after),
      .req_merge_mode   (req_merge_mode),
      .req_has_waiter   (req_has_waiter),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_out_type     (rsp_out_type),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_waiters      (rsp_waiters),
      .rsp_last         (rsp_last)
   );

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word outside a busy window");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("word after last");

endmodule
`default_nettype wire

FILE: bench/apcs_checker.sv
`timescale 1ns / 100ps
module apcs_checker
   import apcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_command_type,
   input  logic [31:0] req_payload,
   input  logic [2:0]  req_priority_req,
   input  logic [15:0] req_delay_after,
   input  logic [1:0]  req_merge_mode,
   input  logic        req_has_waiter,
   input  logic        rsp_strobe,
   input  logic [1:0]  rsp_kind,
   input  logic [15:0] rsp_out_type,
   input  logic [31:0] rsp_out_payload,
   input  logic [3:0]  rsp_waiters,
   input  logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending
);

   localparam int DEPTH = 16;
   localparam int DUE_DEPTH = 256;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] ctype;
      logic [31:0] data;
      logic [3:0]  waiters;
      logic        last;
   } sched_word_t;

   sched_word_t due_q [DUE_DEPTH];
   int          due_head, due_tail;

   logic [15:0] q_type  [DEPTH];
   logic [31:0] q_data  [DEPTH];
   logic [2:0]  q_pri   [DEPTH];
   logic [15:0] q_delay [DEPTH];
   logic [31:0] q_time  [DEPTH];
   logic [3:0]  q_wait  [DEPTH];
   int          fill;
   bit          in_flight;
   logic [31:0] issued_at, now_ms, hold_from;
   logic [15:0] hold_len;
   bit          held_valid;
   logic [15:0] held_type;
   logic [31:0] held_data;
   logic [3:0]  held_wait;
   logic [31:0] cfg_timeout;
   logic [30:0] cfg_bg, cfg_idle;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic void post(logic [1:0] k, logic [15:0] t, logic [31:0] d, logic [3:0] w);
      sched_word_t r;
      r = '{kind: k, ctype: t, data: d, waiters: w, last: 1'b0};
      due_q[due_tail % DUE_DEPTH] = r;
      due_tail++;
   endfunction

   function automatic void move_slot(int dst, int src);
      q_type[dst]  = q_type[src];
      q_data[dst]  = q_data[src];
      q_pri[dst]   = q_pri[src];
      q_delay[dst] = q_delay[src];
      q_time[dst]  = q_time[src];
      q_wait[dst]  = q_wait[src];
   endfunction

   function automatic void drop_head();
      for (int i = 0; i + 1 < fill; i++) move_slot(i, i + 1);
      fill--;
   endfunction

   function automatic longint urgency(int i);
      longint age;
      age = longint'(now_ms - q_time[i]);
      if (q_pri[i] <= PRI_NORMAL) return -age;
      if (q_pri[i] == PRI_BACKGROUND) return longint'(cfg_bg) - age;
      return longint'(cfg_idle) - age;
   endfunction

   function automatic void release_held();
      if (held_valid) begin
         post(KIND_OK, held_type, held_data, held_wait);
         held_valid = 0;
      end
   endfunction

   function automatic void try_issue();
      int     best;
      longint best_u, u;
      bit     strict;
      if (in_flight) return;
      if ((now_ms - hold_from) < {16'd0, hold_len}) return;
      hold_len = 0;
      release_held();
      if (fill == 0) return;
      best = 0;
      best_u = urgency(0);
      for (int i = 1; i < fill; i++) begin
         u = urgency(i);
         strict = q_pri[i] < PRI_NORMAL || q_pri[best] < PRI_NORMAL;
         if (strict ? q_pri[i] < q_pri[best] : u < best_u) begin
            best = i;
            best_u = u;
         end
      end
      // rotate the pick to the head, keeping the others in order
      if (best != 0) begin
         logic [15:0] t; logic [31:0] d; logic [2:0] p;
         logic [15:0] dl; logic [31:0] e; logic [3:0] w;
         t = q_type[best]; d = q_data[best]; p = q_pri[best];
         dl = q_delay[best]; e = q_time[best]; w = q_wait[best];
         for (int i = best; i > 0; i--) move_slot(i, i - 1);
         q_type[0] = t; q_data[0] = d; q_pri[0] = p;
         q_delay[0] = dl; q_time[0] = e; q_wait[0] = w;
      end
      in_flight = 1;
      issued_at = now_ms;
      post(KIND_ISSUE, q_type[0], q_data[0], q_wait[0]);
   endfunction

   function automatic void enqueue(logic [15:0] t, logic [31:0] d, logic [2:0] p,
                                   logic [15:0] dl, logic [1:0] mode, logic w);
      bit merge;
      int n;
      merge = (mode == MERGE_LOW_PRI) ? (p == PRI_BACKGROUND || p == PRI_IDLE)
                                      : (mode == MERGE_ALWAYS);
      if (merge) begin
         for (int i = in_flight ? 1 : 0; i < fill; i++) begin
            if (q_type[i] == t && q_data[i] == d) begin
               n = q_wait[i] + w;
               if (p < q_pri[i]) q_pri[i] = p;
               q_delay[i] = dl;
               q_wait[i] = (n > 15) ? 4'd15 : 4'(n);
               return;
            end
         end
      end
      if (fill >= DEPTH) begin
         post(KIND_REJECT, t, d, {3'd0, w});
         return;
      end
      q_type[fill] = t; q_data[fill] = d; q_pri[fill] = p;
      q_delay[fill] = dl; q_time[fill] = now_ms; q_wait[fill] = {3'd0, w};
      fill++;
      try_issue();
   endfunction

   function automatic void predict(logic [2:0] act, logic [15:0] t, logic [31:0] d,
                                   logic [2:0] p, logic [15:0] dl, logic [1:0] mode,
                                   logic w);
      int first;
      logic [3:0] hw;
      bit head_hit;
      first = due_tail;
      head_hit = in_flight && fill > 0 && q_type[0] == t;
      case (act)
         ACT_ENQUEUE: enqueue(t, d, p, dl, mode, w);
         ACT_RESPONSE: if (head_hit) begin
            hold_from = now_ms;
            hold_len = q_delay[0];
            hw = q_wait[0];
            in_flight = 0;
            drop_head();
            if (hold_len > 0) begin
               release_held();
               held_valid = 1;
               held_type = t;
               held_data = d;
               held_wait = hw;
            end else begin
               post(KIND_OK, t, d, hw);
            end
            try_issue();
         end
         ACT_ERROR: if (head_hit) begin
            hold_from = now_ms;
            hold_len = q_delay[0];
            post(KIND_FAIL, t, 32'd0, q_wait[0]);
            in_flight = 0;
            drop_head();
            try_issue();
         end
         ACT_TICK: begin
            now_ms++;
            if (in_flight && fill > 0 && (now_ms - issued_at) > cfg_timeout) begin
               post(KIND_FAIL, q_type[0], 32'd0, q_wait[0]);
               in_flight = 0;
               drop_head();
            end
            try_issue();
         end
         ACT_CLEAR: if (fill != 0) begin
            for (int i = in_flight ? 1 : 0; i < fill; i++)
               post(KIND_FAIL, q_type[i], 32'd0, q_wait[i]);
            fill = in_flight ? 1 : 0;
            try_issue();
         end
         default: ;
      endcase
      if (due_tail > first) due_q[(due_tail - 1) % DUE_DEPTH].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      sched_word_t want;
      if (reset) begin
         due_head = 0; due_tail = 0;
         fill = 0; in_flight = 0; issued_at = 0; now_ms = 0;
         hold_from = 0; hold_len = 0; held_valid = 0;
         held_type = 0; held_data = 0; held_wait = 0;
         cfg_timeout = TIMEOUT_RESET;
         cfg_bg = BG_PENALTY_RESET;
         cfg_idle = IDLE_PEN_RESET;
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (due_tail == due_head) begin
               report("unexpected word, kind", {30'd0, rsp_kind}, 32'd0);
            end else begin
               want = due_q[due_head % DUE_DEPTH];
               due_head++;
               if (rsp_kind != want.kind) report("kind", {30'd0, rsp_kind}, {30'd0, want.kind});
               if (rsp_out_type != want.ctype)
                  report("out_type", {16'd0, rsp_out_type}, {16'd0, want.ctype});
               if (rsp_out_payload != want.data) report("out_payload", rsp_out_payload, want.data);
               if (rsp_waiters != want.waiters)
                  report("waiters", {28'd0, rsp_waiters}, {28'd0, want.waiters});
               if (rsp_last != want.last) report("last", {31'd0, rsp_last}, {31'd0, want.last});
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_TIMEOUT:    cfg_timeout = pwdata;
               REG_BG_PENALTY: cfg_bg = pwdata[30:0];
               REG_IDLE_PEN:   cfg_idle = pwdata[30:0];
               default: ;
            endcase
         end
         if (start && !busy)
            predict(req_action, req_command_type, req_payload, req_priority_req,
                    req_delay_after, req_merge_mode, req_has_waiter);
      end
      pending <= due_tail - due_head;
   end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import apcs_pkg::*;

   localparam int STALL_LIMIT = 3000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_action = 0;
   logic [15:0] req_command_type = 0;
   logic [31:0] req_payload = 0;
   logic [2:0]  req_priority_req = 0;
   logic [15:0] req_delay_after = 0;
   logic [1:0]  req_merge_mode = 0;
   logic        req_has_waiter = 0;
   logic        rsp_strobe;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_out_type;
   logic [31:0] rsp_out_payload;
   logic [3:0]  rsp_waiters;
   logic        rsp_last;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [3:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count, pending, stall_cycles;
   logic [15:0] issued_type = 0;

   always #6 clock = ~clock;

   aged_priority_command_scheduler_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_command_type(req_command_type),
      .req_payload(req_payload), .req_priority_req(req_priority_req),
      .req_delay_after(req_delay_after), .req_merge_mode(req_merge_mode),
      .req_has_waiter(req_has_waiter),
      .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind), .rsp_out_type(rsp_out_type),
      .rsp_out_payload(rsp_out_payload), .rsp_waiters(rsp_waiters), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   apcs_checker u_checker (.*);

   always @(posedge clock) begin
      if (rsp_strobe && rsp_kind == KIND_ISSUE) issued_type <= rsp_out_type;
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("aged_priority_command_scheduler_core: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send(logic [2:0] act, logic [15:0] t, logic [31:0] d, logic [2:0] p,
                       logic [15:0] dl, logic [1:0] mode, logic w);
      req_action <= act;
      req_command_type <= t;
      req_payload <= d;
      req_priority_req <= p;
      req_delay_after <= dl;
      req_merge_mode <= mode;
      req_has_waiter <= w;
      start <= 1;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic random_words(int n, bit gaps);
      int done, pick;
      logic [2:0] act;
      logic [15:0] t, dl;
      logic [31:0] d;
      done = 0;
      while (done < n) begin
         pick = $urandom_range(0, 99);
         t = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
         d = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 2));
         dl = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 3)) : 16'd0;
         if (pick < 45) act = ACT_ENQUEUE;
         else if (pick < 65) act = ACT_RESPONSE;
         else if (pick < 73) act = ACT_ERROR;
         else if (pick < 93) act = ACT_TICK;
         else if (pick < 98) act = ACT_CLEAR;
         else act = 3'($urandom_range(5, 7));
         if ((act == ACT_RESPONSE || act == ACT_ERROR) && $urandom_range(0, 4) != 0)
            t = issued_type;
         if (act == ACT_RESPONSE) d = $urandom;
         send(act, t, d, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4)),
              dl, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         if (act <= ACT_CLEAR) done++;
         if (gaps && $urandom_range(0, 3) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
      start <= 0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      // fill the queue behind one command in flight
      send(ACT_CLEAR, 0, 0, 0, 0, 2'd2, 0);
      send(ACT_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF, 3'd0, 16'd0, 2'd2, 1);
      for (int i = 1; i < 16; i++)
         send(ACT_ENQUEUE, 16'(i), 32'(i), 3'(i % 5), 16'd0, 2'd2, 0);
      send(ACT_ENQUEUE, 16'd3, 32'd3, 3'd2, 16'hFFFF, MERGE_ALWAYS, 1);
      send(ACT_ENQUEUE, 16'h0100, 32'h5555_AAAA, 3'd7, 16'hFFFF, 2'd3, 1);
      send(ACT_RESPONSE, 16'h1234, 32'd9, 0, 0, 0, 0);
      send(ACT_RESPONSE, 16'hFFFF, 32'hAAAA_5555, 0, 0, 0, 0);
      send(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
      send(ACT_ERROR, 16'd5, 0, 0, 0, 0, 0);
      drain();

      csr_write(REG_TIMEOUT, 32'd0);
      send(ACT_ENQUEUE, 16'd7, 32'd7, 3'd4, 16'hFFFF, MERGE_LOW_PRI, 1);
      send(ACT_TICK, 0, 0, 0, 0, 0, 0);
      drain();
      csr_write(REG_TIMEOUT, 32'hFFFF_FFFF);
      send(ACT_ENQUEUE, 16'd8, 32'd8, 3'd3, 16'd2, MERGE_LOW_PRI, 0);
      send(ACT_RESPONSE, 16'd8, 32'h0F0F_0F0F, 0, 0, 0, 0);
      send(ACT_TICK, 0, 0, 0, 0, 0, 0);
      send(ACT_TICK, 0, 0, 0, 0, 0, 0);
      drain();

      csr_write(REG_TIMEOUT, 32'd3);
      csr_write(REG_BG_PENALTY, 32'd0);
      csr_write(REG_IDLE_PEN, 32'h7FFF_FFFF);
      random_words(20, 1);
      drain();
      random_words(15, 1);
      drain();

      csr_write(REG_BG_PENALTY, 32'h7FFF_FFFF);
      csr_write(REG_IDLE_PEN, 32'd0);
      random_words(30, 1);
      drain();

      csr_write(REG_TIMEOUT, 32'd2);
      csr_write(REG_BG_PENALTY, 32'd4);
      csr_write(REG_IDLE_PEN, 32'd9);
      random_words(10, 1);
      random_words(25, 0);
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("aged_priority_command_scheduler_core: match");
      end else begin
         $display("aged_priority_command_scheduler_core: mismatch");
      end
      $finish;
   end

endmodule
